/* rtl/core/tlpw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpw_pkg
// Shared types and constants of the two-level page table walker.
// ----------------------------------------------------------------------------
package tlpw_pkg;

    localparam logic [1:0] OP_XLATE = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_REMAP = 2'd3;

    localparam logic [1:0] CFG_PAGING_ON = 2'd0;
    localparam logic [1:0] CFG_DIR_BASE  = 2'd1;
    localparam logic [1:0] CFG_USER_MODE = 2'd2;

    localparam int unsigned BIT_PRESENT  = 0;
    localparam int unsigned BIT_WRITABLE = 1;
    localparam int unsigned BIT_USER     = 2;
    localparam int unsigned BIT_ACCESSED = 5;
    localparam int unsigned BIT_DIRTY    = 6;

    localparam logic [2:0] ERR_PROT  = 3'b001;
    localparam logic [2:0] ERR_WRITE = 3'b010;
    localparam logic [2:0] ERR_USER  = 3'b100;

    localparam logic [1:0] LEVEL_USER = 2'b11;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ISSUE,
        S_READ,
        S_REMAP,
        S_DIR,
        S_ENT,
        S_WDIR,
        S_WENT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic st_we;
        logic st_re;
        logic rm_we;
        logic rm_re;
    } t_mem_ctl;

    typedef struct packed {
        logic [31:0] read_word;
        logic [31:0] fault_address;
        logic [2:0]  error_code;
        logic        fault;
        logic [19:0] physical_page;
    } t_result;

endpackage

/* rtl/core/two_level_page_table_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_walker
// Translates linear addresses through a two-level page table held in a local
// single-port word memory; also loads and reads table words and loads remap entries.
// ----------------------------------------------------------------------------
// A table or remap write goes straight to the response; a table read or an
// unpaged translation makes one memory read. A walk reads the directory and page
// entries; when it succeeds it also sets their accessed bits and, for a write,
// the dirty bit. One request is in flight at a time, so a new request is taken
// only once the result has moved into the output register. After reset a
// clearing pass zeroes the table and loads the remap identity; requests wait for it.
// ----------------------------------------------------------------------------
module two_level_page_table_walker #(
    parameter int STORE_ADDRESS_BITS = 14,
    parameter int REMAP_PAGES        = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [19:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // linear_address, is_write, current_level, memory_level, store_address,
    // store_data, remap_index, zero fill
    input  logic [111:0] s_axis_tdata,
    // operation
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // physical_page, fault, error_code, fault_address, read_word
    output logic [87:0]  m_axis_tdata
);
    import tlpw_pkg::*;

    localparam int SW  = STORE_ADDRESS_BITS - 2;
    localparam int RIW = (REMAP_PAGES > 1) ? $clog2(REMAP_PAGES) : 1;

    t_state        r_state;
    t_state        n_state;

    logic          r_paging_on;
    logic [19:0]   r_dir_base;
    logic          r_user_mode;

    logic [1:0]    r_op;
    logic [31:0]   r_lin;
    logic          r_wr;
    logic [1:0]    r_lvl;
    logic [31:0]   r_saddr;
    logic [31:0]   r_sdata;
    logic [7:0]    r_ridx;
    logic [31:0]   r_dir;
    logic [31:0]   r_ent;
    logic [31:0]   r_ent_new;
    logic [SW-1:0] r_ent_idx;
    t_result       r_pend;
    t_result       r_out;
    logic          r_out_valid;

    t_mem_ctl      mem_ctl;
    logic [SW-1:0] st_addr;
    logic [31:0]   st_wdata;
    logic [RIW-1:0] rm_addr;
    logic [19:0]   rm_wdata;
    logic [31:0]   st_rdata;
    logic [19:0]   rm_rdata;
    logic          clearing;

    logic          accept;
    logic          out_free;
    logic [29:0]   dir_word;
    logic [29:0]   ent_word;
    logic [31:0]   lin_page_ext;
    logic [31:0]   ridx_ext;
    logic          lin_remapped;
    logic          ridx_ok;
    logic [2:0]    np_err;
    logic          ent_present;
    logic          user_fail;
    logic          read_only;
    logic          prot_fault;
    logic          walk_ok;
    logic [31:0]   ent_new;

    tlpw_store #(
        .STORE_ADDRESS_BITS (STORE_ADDRESS_BITS),
        .REMAP_PAGES        (REMAP_PAGES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mem_ctl),
        .i_st_addr  (st_addr),
        .i_st_wdata (st_wdata),
        .i_rm_addr  (rm_addr),
        .i_rm_wdata (rm_wdata),
        .o_st_rdata (st_rdata),
        .o_rm_rdata (rm_rdata),
        .o_clearing (clearing)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !clearing;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign dir_word     = {r_dir_base, r_lin[31:22]};
    assign ent_word     = {st_rdata[31:12], r_lin[21:12]};
    assign lin_page_ext = {12'd0, r_lin[31:12]};
    assign ridx_ext     = {24'd0, r_ridx};
    assign lin_remapped = lin_page_ext < 32'(REMAP_PAGES);
    assign ridx_ok      = ridx_ext < 32'(REMAP_PAGES);

    // Entry checks, valid in S_ENT where the memory shows the page entry.
    always_comb begin
        np_err      = (r_wr ? ERR_WRITE : 3'b000) | ((r_lvl != 2'b00) ? ERR_USER : 3'b000);
        ent_present = st_rdata[BIT_PRESENT];
        if (r_user_mode) begin
            user_fail = !st_rdata[BIT_USER] || !r_dir[BIT_USER];
        end else begin
            user_fail = !st_rdata[BIT_USER] && !r_dir[BIT_USER];
        end
        read_only  = !st_rdata[BIT_WRITABLE] || !r_dir[BIT_WRITABLE];
        prot_fault = (r_lvl == LEVEL_USER) && (user_fail || (read_only && r_wr));
        walk_ok    = ent_present && !prot_fault;
        ent_new    = st_rdata;
        ent_new[BIT_ACCESSED] = 1'b1;
        if (r_wr) begin
            ent_new[BIT_DIRTY] = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                unique case (r_op)
                    OP_WRITE: n_state = S_RESP;
                    OP_REMAP: n_state = S_RESP;
                    OP_READ:  n_state = S_READ;
                    OP_XLATE: n_state = r_paging_on ? S_DIR : S_REMAP;
                    default:  n_state = S_RESP;
                endcase
            end
            S_READ:  n_state = S_RESP;
            S_REMAP: n_state = S_RESP;
            S_DIR:   n_state = st_rdata[BIT_PRESENT] ? S_ENT : S_RESP;
            S_ENT:   n_state = walk_ok ? S_WDIR : S_RESP;
            S_WDIR:  n_state = S_WENT;
            S_WENT:  n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_ctl  = '0;
        st_addr  = r_saddr[SW+1:2];
        st_wdata = r_sdata;
        rm_addr  = ridx_ext[RIW-1:0];
        rm_wdata = r_sdata[19:0];
        unique case (r_state)
            S_ISSUE: begin
                unique case (r_op)
                    OP_WRITE: mem_ctl.st_we = 1'b1;
                    OP_READ:  mem_ctl.st_re = 1'b1;
                    OP_REMAP: mem_ctl.rm_we = ridx_ok;
                    OP_XLATE: begin
                        if (r_paging_on) begin
                            mem_ctl.st_re = 1'b1;
                            st_addr       = dir_word[SW-1:0];
                        end else begin
                            mem_ctl.rm_re = lin_remapped;
                            rm_addr       = lin_page_ext[RIW-1:0];
                        end
                    end
                    default: mem_ctl = '0;
                endcase
            end
            S_DIR: begin
                mem_ctl.st_re = st_rdata[BIT_PRESENT];
                st_addr       = ent_word[SW-1:0];
            end
            S_WDIR: begin
                mem_ctl.st_we = !r_dir[BIT_ACCESSED];
                st_addr       = dir_word[SW-1:0];
                st_wdata      = r_dir | (32'd1 << BIT_ACCESSED);
            end
            S_WENT: begin
                mem_ctl.st_we = r_ent_new != r_ent;
                st_addr       = r_ent_idx;
                st_wdata      = r_ent_new;
            end
            default: mem_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_paging_on <= 1'b0;
            r_dir_base  <= '0;
            r_user_mode <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PAGING_ON: r_paging_on <= i_cfg_wdata[0];
                    CFG_DIR_BASE:  r_dir_base  <= i_cfg_wdata;
                    CFG_USER_MODE: r_user_mode <= i_cfg_wdata[0];
                    default:       r_user_mode <= r_user_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_op    <= s_axis_tuser;
                    r_lin   <= s_axis_tdata[31:0];
                    r_wr    <= s_axis_tdata[32];
                    r_lvl   <= s_axis_tdata[34:33] & s_axis_tdata[36:35];
                    r_saddr <= s_axis_tdata[68:37];
                    r_sdata <= s_axis_tdata[100:69];
                    r_ridx  <= s_axis_tdata[108:101];
                end
            end
            S_ISSUE: begin
                r_pend <= '0;
            end
            S_READ: begin
                r_pend.read_word <= st_rdata;
            end
            S_REMAP: begin
                r_pend.physical_page <= lin_remapped ? rm_rdata : r_lin[31:12];
            end
            S_DIR: begin
                r_dir     <= st_rdata;
                r_ent_idx <= ent_word[SW-1:0];
                if (!st_rdata[BIT_PRESENT]) begin
                    r_pend.fault         <= 1'b1;
                    r_pend.error_code    <= np_err;
                    r_pend.fault_address <= r_lin;
                end
            end
            S_ENT: begin
                r_ent     <= st_rdata;
                r_ent_new <= ent_new;
                if (!ent_present) begin
                    r_pend.fault         <= 1'b1;
                    r_pend.error_code    <= np_err;
                    r_pend.fault_address <= r_lin;
                end else if (prot_fault) begin
                    r_pend.fault         <= 1'b1;
                    r_pend.error_code    <= ERR_PROT | ERR_USER | (r_wr ? ERR_WRITE : 3'b000);
                    r_pend.fault_address <= r_lin;
                end else begin
                    r_pend.physical_page <= st_rdata[31:12];
                end
            end
            S_RESP: begin
                if (out_free) begin
                    r_out <= r_pend;
                end
            end
            default: begin
                r_pend <= r_pend;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.read_word, r_out.fault_address, r_out.error_code,
                            r_out.fault, r_out.physical_page};

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !s_axis_tready)
        else $error("request accepted during clearing pass");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("second request accepted while one is in flight");

    a_fault_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.fault) |->
            (r_out.physical_page == 20'd0 && r_out.read_word == 32'd0))
        else $error("faulting result carries a page or read word");

    a_clean_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_out.fault) |->
            (r_out.error_code == 3'd0 && r_out.fault_address == 32'd0))
        else $error("result without fault carries error fields");

endmodule

/* rtl/core/tlpw_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpw_store
// Table word memory and low page remap memory with a clearing pass after
// reset that zeroes the table and loads the remap memory with identity.
// ----------------------------------------------------------------------------
module tlpw_store #(
    parameter int STORE_ADDRESS_BITS = 14,
    parameter int REMAP_PAGES        = 256,
    parameter int SW                 = STORE_ADDRESS_BITS - 2,
    parameter int RIW                = (REMAP_PAGES > 1) ? $clog2(REMAP_PAGES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlpw_pkg::t_mem_ctl i_ctl,
    input  logic [SW-1:0]      i_st_addr,
    input  logic [31:0]        i_st_wdata,
    input  logic [RIW-1:0]     i_rm_addr,
    input  logic [19:0]        i_rm_wdata,
    output logic [31:0]        o_st_rdata,
    output logic [19:0]        o_rm_rdata,
    output logic               o_clearing
);
    import tlpw_pkg::*;

    localparam int STORE_WORDS = 1 << SW;

    logic [31:0]   mem_table [STORE_WORDS];
    logic [19:0]   mem_remap [REMAP_PAGES];

    logic          r_clr_active;
    logic [SW-1:0] r_clr_cnt;
    logic [31:0]   r_st_rdata;
    logic [19:0]   r_rm_rdata;
    logic [31:0]   clr_ext;
    logic          clr_remap;

    assign clr_ext   = {{(32 - SW){1'b0}}, r_clr_cnt};
    assign clr_remap = clr_ext < 32'(REMAP_PAGES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_cnt    <= '0;
        end else if (r_clr_active) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == {SW{1'b1}}) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            mem_table[r_clr_cnt] <= '0;
        end else if (i_ctl.st_we) begin
            mem_table[i_st_addr] <= i_st_wdata;
        end
        if (i_ctl.st_re) begin
            r_st_rdata <= mem_table[i_st_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            if (clr_remap) begin
                mem_remap[clr_ext[RIW-1:0]] <= clr_ext[19:0];
            end
        end else if (i_ctl.rm_we) begin
            mem_remap[i_rm_addr] <= i_rm_wdata;
        end
        if (i_ctl.rm_re) begin
            r_rm_rdata <= mem_remap[i_rm_addr];
        end
    end

    assign o_st_rdata = r_st_rdata;
    assign o_rm_rdata = r_rm_rdata;
    assign o_clearing = r_clr_active;

endmodule
